/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the banked FIR filter; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BFIR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFIR_ASSERT(lbl, clk, rst, prop, msg)
`define BFIR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/bfir_pkg.sv */
// ---------------------------------------------------------------------------
// bfir_pkg
// Shared types, constants and helper functions of the banked FIR filter.
// ---------------------------------------------------------------------------
`default_nettype none

package bfir_pkg;

  localparam int TAPS_DEF   = 16;
  localparam int BANKS_DEF  = 4;

  localparam int BANK_W     = 2;
  localparam int TAP_W      = 4;
  localparam int COEF_W     = 16;
  localparam int SAMPLE_W   = 24;
  localparam int OUT_W      = 24;

  localparam int PROD_SHIFT = 8;
  localparam int SUM_SHIFT  = 7;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int TERM_W     = PROD_W - PROD_SHIFT;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic live;
  } mac_ctl_t;

  function automatic logic signed [COEF_W-1:0] sm_to_coef(input logic [COEF_W-1:0] raw);
    logic [COEF_W-1:0] mag;
    mag = {1'b0, raw[COEF_W-2:0]};
    return raw[COEF_W-1] ? signed'(-mag) : signed'(mag);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] adjust_sample(
    input logic signed [SAMPLE_W-1:0] s
  );
    return s + SAMPLE_W'(s[SAMPLE_W-1]);
  endfunction

endpackage

`default_nettype wire

/* rtl/bfir_mem.sv */
// ---------------------------------------------------------------------------
// bfir_mem
// Single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bfir_mem #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/bfir_mac.sv */
// ---------------------------------------------------------------------------
// bfir_mac
// Shared multiply-accumulate unit with final scaling and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module bfir_mac #(
  parameter int TAPS = bfir_pkg::TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bfir_pkg::mac_ctl_t                  ctl,
  input  logic signed [bfir_pkg::COEF_W-1:0]  coef,
  input  logic signed [bfir_pkg::SAMPLE_W-1:0] smp,
  output logic                                busy,
  output logic [bfir_pkg::OUT_W-1:0]          result
);

  import bfir_pkg::*;

  localparam int ACC_W   = TERM_W + $clog2(TAPS);
  localparam int MAX_I   = (1 << (OUT_W - 1)) - 1;
  localparam int MIN_I   = -(1 << (OUT_W - 1));
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(MAX_I);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(MIN_I);

  logic                     s1_valid;
  logic                     s1_live;
  logic                     s2_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SAMPLE_W-1:0] x_adj;
  logic signed [PROD_W-1:0] x_ext;
  logic signed [PROD_W-1:0] c_ext;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  sat;

  always_comb begin
    x_adj = adjust_sample(smp);
    x_ext = PROD_W'(x_adj);
    c_ext = PROD_W'(coef);
    term  = TERM_W'(prod >>> PROD_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_live <= ctl.live;
    prod    <= s1_live ? x_ext * c_ext : '0;
    if (ctl.clear) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + ACC_W'(term);
    end
  end

  always_comb begin
    scaled = acc >>> SUM_SHIFT;
    if (scaled > ACC_MAX) begin
      sat = ACC_MAX;
    end else if (scaled < ACC_MIN) begin
      sat = ACC_MIN;
    end else begin
      sat = scaled;
    end
    result = sat[OUT_W-1:0];
    busy   = s1_valid | s2_valid;
  end

endmodule

`default_nettype wire

/* rtl/bfir_ctrl.sv */
// ---------------------------------------------------------------------------
// bfir_ctrl
// Sequencer: accepts items, keeps per-bank ring pointers and fill counts,
// and steps the shared MAC over the taps of the selected bank.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bfir_ctrl #(
  parameter int TAPS  = bfir_pkg::TAPS_DEF,
  parameter int BANKS = bfir_pkg::BANKS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   cmd,
  input  logic [bfir_pkg::BANK_W-1:0]            bank,
  input  logic [bfir_pkg::TAP_W-1:0]             tap_index,
  input  logic                                   frame_end,
  input  logic                                   out_free,
  output logic                                   out_load,
  output logic                                   fend_hold,
  input  logic                                   mac_busy,
  output bfir_pkg::mac_ctl_t                     mac_ctl,
  output logic                                   coef_we,
  output logic [$clog2(BANKS*TAPS)-1:0]          coef_waddr,
  output logic [$clog2(BANKS*TAPS)-1:0]          coef_raddr,
  output logic                                   delay_we,
  output logic [$clog2(BANKS*TAPS)-1:0]          delay_waddr,
  output logic [$clog2(BANKS*TAPS)-1:0]          delay_raddr
);

  import bfir_pkg::*;

  localparam int DEPTH = BANKS * TAPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(TAPS);
  localparam int FW    = $clog2(TAPS + 1);
  localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;

  ctrl_state_t   state, state_next;
  logic [BW-1:0] cur_bank;
  logic [TW-1:0] cur_ptr;
  logic [FW-1:0] cur_fill;
  logic [TW-1:0] tap_cnt;
  logic [TW-1:0] wptr [BANKS];
  logic [FW-1:0] fill [BANKS];

  logic          accept;
  logic          bank_ok;
  logic          tap_ok;
  logic          start;
  logic          last_tap;
  logic [BW-1:0] bank_idx;
  logic [TW-1:0] ptr_sel;
  logic [FW-1:0] fill_sel;
  logic [TW-1:0] ptr_next;
  logic [FW-1:0] fill_next;
  logic [TW-1:0] rd_pos;

  always_comb begin
    in_stall  = (state != ST_IDLE);
    accept    = in_valid && !in_stall;
    bank_ok   = (32'(bank) < BANKS);
    tap_ok    = (32'(tap_index) < TAPS);
    bank_idx  = BW'(bank);
    ptr_sel   = wptr[bank_idx];
    fill_sel  = fill[bank_idx];
    start     = accept && bank_ok && (cmd == CMD_FILTER);
    coef_we   = accept && bank_ok && (cmd == CMD_COEF) && tap_ok;
    delay_we  = start;
    ptr_next  = (ptr_sel == TW'(TAPS - 1)) ? '0 : ptr_sel + TW'(1);
    fill_next = (fill_sel == FW'(TAPS)) ? fill_sel : fill_sel + FW'(1);
    last_tap  = (tap_cnt == TW'(TAPS - 1));
    rd_pos    = (cur_ptr >= tap_cnt) ? cur_ptr - tap_cnt
                                     : TW'(int'(cur_ptr) + TAPS - int'(tap_cnt));

    coef_waddr  = AW'(int'(bank_idx) * TAPS + int'(tap_index));
    delay_waddr = AW'(int'(bank_idx) * TAPS + int'(ptr_sel));
    coef_raddr  = AW'(int'(cur_bank) * TAPS + int'(tap_cnt));
    delay_raddr = AW'(int'(cur_bank) * TAPS + int'(rd_pos));

    out_load      = (state == ST_DRAIN) && !mac_busy && out_free;
    mac_ctl.clear = start;
    mac_ctl.issue = (state == ST_ISSUE);
    mac_ctl.live  = (FW'(tap_cnt) < cur_fill);

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (last_tap) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_cnt  <= '0;
      cur_fill <= '0;
      for (int b = 0; b < BANKS; b++) begin
        wptr[b] <= '0;
        fill[b] <= '0;
      end
    end else if (start) begin
      tap_cnt         <= '0;
      cur_fill        <= fill_next;
      wptr[bank_idx]  <= ptr_next;
      fill[bank_idx]  <= fill_next;
    end else if (state == ST_ISSUE && !last_tap) begin
      tap_cnt <= tap_cnt + TW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_bank  <= bank_idx;
      cur_ptr   <= ptr_sel;
      fend_hold <= frame_end;
    end
  end

  `BFIR_ASSERT(a_start_issue, clk, rst, start |=> (state == ST_ISSUE && tap_cnt == '0), "sample did not start tap sweep at tap zero")
  `BFIR_ASSERT(a_issue_filled, clk, rst, (state == ST_ISSUE) |-> (cur_fill != '0), "tap sweep with empty delay line")
  `BFIR_ASSERT(a_drain_busy, clk, rst, (state == ST_DRAIN && $past(state) == ST_ISSUE) |-> mac_busy, "MAC pipeline empty on entering drain")

endmodule

`default_nettype wire

/* rtl/banked_fir_filter_24bit_core.sv */
// ---------------------------------------------------------------------------
// banked_fir_filter_24bit_core
// Banked direct-form FIR filter: per-bank coefficients and delay lines,
// one shared multiply-accumulate unit, saturated 24-bit output.
// ---------------------------------------------------------------------------
// A coefficient write is done when it is accepted. A sample item is accepted
// and stored, then the single multiplier visits one tap per cycle over all
// TAPS taps, then the block drains the memory-read and multiply stages and
// loads the result once the output register is free. The result
// waits in an output register, so the next item is accepted while it is held.
// ---------------------------------------------------------------------------
`default_nettype none

module banked_fir_filter_24bit_core #(
  parameter int TAPS  = bfir_pkg::TAPS_DEF,
  parameter int BANKS = bfir_pkg::BANKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [bfir_pkg::BANK_W-1:0]         bank,
  input  logic [bfir_pkg::TAP_W-1:0]          tap_index,
  input  logic [bfir_pkg::COEF_W-1:0]         coef_raw,
  input  logic signed [bfir_pkg::SAMPLE_W-1:0] sample,
  input  logic                                frame_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bfir_pkg::OUT_W-1:0]          filtered,
  output logic                                frame_end_out
);

  import bfir_pkg::*;

  localparam int DEPTH = BANKS * TAPS;
  localparam int AW    = $clog2(DEPTH);

  mac_ctl_t                  mac_ctl;
  logic                      mac_busy;
  logic [OUT_W-1:0]          mac_result;
  logic                      out_free;
  logic                      out_load;
  logic                      fend_hold;
  logic                      coef_we;
  logic [AW-1:0]             coef_waddr;
  logic [AW-1:0]             coef_raddr;
  logic                      delay_we;
  logic [AW-1:0]             delay_waddr;
  logic [AW-1:0]             delay_raddr;
  logic [COEF_W-1:0]         coef_wdata;
  logic [COEF_W-1:0]         coef_rdata;
  logic [SAMPLE_W-1:0]       delay_rdata;

  assign out_free   = !out_valid || !out_stall;
  assign coef_wdata = sm_to_coef(coef_raw);

  bfir_ctrl #(
    .TAPS  (TAPS),
    .BANKS (BANKS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .bank        (bank),
    .tap_index   (tap_index),
    .frame_end   (frame_end),
    .out_free    (out_free),
    .out_load    (out_load),
    .fend_hold   (fend_hold),
    .mac_busy    (mac_busy),
    .mac_ctl     (mac_ctl),
    .coef_we     (coef_we),
    .coef_waddr  (coef_waddr),
    .coef_raddr  (coef_raddr),
    .delay_we    (delay_we),
    .delay_waddr (delay_waddr),
    .delay_raddr (delay_raddr)
  );

  bfir_mem #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_coef_mem (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  bfir_mem #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_delay_mem (
    .clk   (clk),
    .we    (delay_we),
    .waddr (delay_waddr),
    .wdata (sample),
    .raddr (delay_raddr),
    .rdata (delay_rdata)
  );

  bfir_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .coef   (signed'(coef_rdata)),
    .smp    (signed'(delay_rdata)),
    .busy   (mac_busy),
    .result (mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered      <= mac_result;
      frame_end_out <= fend_hold;
    end
  end

endmodule

`default_nettype wire

/* test/bfir_result_checker.sv */
// ---------------------------------------------------------------------------
// bfir_result_checker
// Watches both channels of the banked FIR core. It keeps its own coefficient
// and delay-line state, predicts the filtered output of every sample item and
// compares each output item, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bfir_result_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 cmd,
  input  logic [bfir_pkg::BANK_W-1:0]          bank,
  input  logic [bfir_pkg::TAP_W-1:0]           tap_index,
  input  logic [bfir_pkg::COEF_W-1:0]          coef_raw,
  input  logic signed [bfir_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 frame_end,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [bfir_pkg::OUT_W-1:0]           filtered,
  input  logic                                 frame_end_out,
  output int                                   mismatch_count,
  output int                                   results_pending
);

  localparam int     NUM_BANKS = bfir_pkg::BANKS_DEF;
  localparam int     NUM_TAPS  = bfir_pkg::TAPS_DEF;
  localparam longint SAT_HI    = 64'sd8388607;
  localparam longint SAT_LO    = -64'sd8388608;

  typedef struct packed {
    logic [bfir_pkg::OUT_W-1:0] filtered;
    logic                       frame_end;
  } fir_result_t;

  fir_result_t                        pending_outputs[$];
  logic signed [bfir_pkg::COEF_W-1:0]   coef_bank[NUM_BANKS][NUM_TAPS];
  logic signed [bfir_pkg::SAMPLE_W-1:0] delay_bank[NUM_BANKS][NUM_TAPS];

  initial mismatch_count = 0;
  initial results_pending = 0;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count = mismatch_count + 1;
  endtask

  function automatic logic signed [bfir_pkg::COEF_W-1:0] to_coef(
    input logic [bfir_pkg::COEF_W-1:0] raw
  );
    logic signed [bfir_pkg::COEF_W-1:0] mag;
    mag = {1'b0, raw[bfir_pkg::COEF_W-2:0]};
    if (raw[bfir_pkg::COEF_W-1]) begin
      return -mag;
    end
    return mag;
  endfunction

  // Advance the bank's delay line, then run the full tap sum.
  function automatic logic [bfir_pkg::OUT_W-1:0] filter_sample(
    input int b,
    input logic signed [bfir_pkg::SAMPLE_W-1:0] s
  );
    longint acc;
    longint x;
    acc = 0;
    for (int j = NUM_TAPS - 1; j > 0; j--) begin
      delay_bank[b][j] = delay_bank[b][j-1];
    end
    delay_bank[b][0] = s;
    for (int j = 0; j < NUM_TAPS; j++) begin
      x = delay_bank[b][j];
      if (x < 0) begin
        x = x + 1;
      end
      acc = acc + ((x * longint'(coef_bank[b][j])) >>> bfir_pkg::PROD_SHIFT);
    end
    acc = acc >>> bfir_pkg::SUM_SHIFT;
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    return acc[bfir_pkg::OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    fir_result_t want;
    if (rst) begin
      pending_outputs.delete();
      for (int b = 0; b < NUM_BANKS; b++) begin
        for (int t = 0; t < NUM_TAPS; t++) begin
          delay_bank[b][t] = '0;
        end
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_outputs.size() == 0) begin
          report_mismatch($sformatf("output item 0x%06h with no item pending", filtered));
        end else begin
          want = pending_outputs.pop_front();
          if (filtered !== want.filtered) begin
            report_mismatch($sformatf("filtered 0x%06h, predicted 0x%06h",
                                      filtered, want.filtered));
          end
          if (frame_end_out !== want.frame_end) begin
            report_mismatch($sformatf("frame_end_out %b, predicted %b",
                                      frame_end_out, want.frame_end));
          end
        end
      end
      if (in_valid && !in_stall && int'(bank) < NUM_BANKS) begin
        if (cmd == bfir_pkg::CMD_COEF) begin
          if (int'(tap_index) < NUM_TAPS) begin
            coef_bank[bank][tap_index] = to_coef(coef_raw);
          end
        end else begin
          want.filtered  = filter_sample(int'(bank), sample);
          want.frame_end = frame_end;
          pending_outputs.push_back(want);
        end
      end
    end
    results_pending <= pending_outputs.size();
  end

endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus for the banked FIR core: loads every coefficient, runs directed
// extremes and saturation cases, then random sample and coefficient items
// under varying sender gaps and receiver stalls. The checker does the
// prediction and comparison; this module gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int NUM_BANKS = bfir_pkg::BANKS_DEF;
  localparam int NUM_TAPS  = bfir_pkg::TAPS_DEF;

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_stall;
  logic                                 cmd;
  logic [bfir_pkg::BANK_W-1:0]          bank;
  logic [bfir_pkg::TAP_W-1:0]           tap_index;
  logic [bfir_pkg::COEF_W-1:0]          coef_raw;
  logic signed [bfir_pkg::SAMPLE_W-1:0] sample;
  logic                                 frame_end;
  logic                                 out_valid;
  logic                                 out_stall;
  logic [bfir_pkg::OUT_W-1:0]           filtered;
  logic                                 frame_end_out;
  int                                   mismatch_count;
  int                                   results_pending;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;

  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7fffff;
  localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

  banked_fir_filter_24bit_core i_dut (.*);

  bfir_result_checker i_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(input logic c, input logic [1:0] b, input logic [3:0] t,
                           input logic [15:0] r, input logic signed [23:0] s,
                           input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    bank      <= b;
    tap_index <= t;
    coef_raw  <= r;
    sample    <= s;
    frame_end <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_coef(input logic [1:0] b, input logic [3:0] t, input logic [15:0] r);
    send_item(bfir_pkg::CMD_COEF, b, t, r, 24'($urandom), 1'($urandom));
  endtask

  task automatic filter_one(input logic [1:0] b, input logic signed [23:0] s, input logic f);
    send_item(bfir_pkg::CMD_FILTER, b, 4'($urandom), 16'($urandom), s, f);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return 24'($urandom_range(511)) - 24'sd256;
      3:       return -24'sd1;
      4:       return 24'($urandom_range(65535));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'hffff;
      2:       return 16'h8000;
      3:       return 16'h0000;
      4, 5:    return {1'($urandom), 7'd0, 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        write_coef(2'($urandom), 4'($urandom), pick_coef());
      end else begin
        filter_one(2'($urandom), pick_sample(), 1'($urandom));
      end
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    cmd       <= bfir_pkg::CMD_FILTER;
    bank      <= '0;
    tap_index <= '0;
    coef_raw  <= '0;
    sample    <= '0;
    frame_end <= 1'b0;
    rst       <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 13;
    stall_pct     = 63;

    // load every tap of every bank before any sample reads them
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        write_coef(2'(b), 4'(t), (b == NUM_BANKS - 1) ? 16'h7fff : pick_coef());
      end
    end

    write_coef(2'd0, 4'd0, 16'h8000);
    write_coef(2'd0, 4'd15, 16'hffff);
    write_coef(2'd1, 4'd7, 16'h0000);
    filter_one(2'd0, 24'sd0, 1'b0);
    filter_one(2'd0, -24'sd1, 1'b1);
    filter_one(2'd0, SAMPLE_MAX, 1'b0);
    filter_one(2'd0, SAMPLE_MIN, 1'b1);
    filter_one(2'd1, SAMPLE_MIN, 1'b0);
    filter_one(2'd2, SAMPLE_MAX, 1'b1);
    // all-max coefficients: positive then negative saturation
    filter_one(2'd3, SAMPLE_MAX, 1'b0);
    filter_one(2'd3, SAMPLE_MAX, 1'b0);
    filter_one(2'd3, SAMPLE_MIN, 1'b0);
    filter_one(2'd3, SAMPLE_MIN, 1'b0);
    filter_one(2'd3, SAMPLE_MIN, 1'b0);
    filter_one(2'd3, SAMPLE_MIN, 1'b1);
    write_coef(2'd3, 4'd15, 16'hffff);
    filter_one(2'd3, -24'sd2, 1'b0);
    filter_one(2'd3, 24'sd1, 1'b1);
    write_coef(2'd3, 4'd0, 16'h0001);
    filter_one(2'd3, SAMPLE_MAX, 1'b0);

    run_random(580);

    send_idle_pct = 63;
    stall_pct     = 13;
    run_random(290);
    drain_results();
    run_random(290);

    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 300;
    run_random(580);

    drain_results();
    repeat (NUM_TAPS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
